>>> rtl/core/tged_pkg.sv
// Shared types and constants for the touch gesture event detector.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package tged_pkg;

   // Default sizes of the coordinate and time paths
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int TIME_BITS_DEFAULT  = 32;

   // Fixed register and port widths
   localparam int CFG_DIM_BITS    = 12;
   localparam int CFG_DELAY_BITS  = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int EVENT_BITS      = 3;
   localparam int COUNT_BITS      = 2;

   // Register reset values
   localparam logic [1:0]                RESET_ROTATION = 2'd0;
   localparam logic [CFG_DIM_BITS-1:0]   RESET_WIDTH    = 12'd320;
   localparam logic [CFG_DIM_BITS-1:0]   RESET_HEIGHT   = 12'd240;
   localparam logic [CFG_DELAY_BITS-1:0] RESET_LONG_MS  = 16'd2000;

   // Extra hold added to the current time to form the new press time once a long press fires
   localparam int LONG_HOLD_EXTRA_MS = 10000;

   // Touch counts with a meaning of their own
   localparam logic [COUNT_BITS-1:0] TOUCH_NONE = 2'd0;
   localparam logic [COUNT_BITS-1:0] TOUCH_ONE  = 2'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROTATION      = 3'd0,
      CSR_MIRROR_HORIZ  = 3'd1,
      CSR_MIRROR_VERT   = 3'd2,
      CSR_WIDTH_PIXELS  = 3'd3,
      CSR_HEIGHT_PIXELS = 3'd4,
      CSR_LONG_PRESS_MS = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rotation_type;

   typedef enum logic [EVENT_BITS-1:0] {
      EV_PRESSED       = 3'd0,
      EV_MOVED         = 3'd1,
      EV_LONG_PRESSED  = 3'd2,
      EV_RELEASED      = 3'd3,
      EV_LONG_RELEASED = 3'd4
   } event_kind_type;

   typedef struct packed {
      rotation_type                rotation;
      logic                        mirror_horizontal;
      logic                        mirror_vertical;
      logic [CFG_DIM_BITS-1:0]     width_pixels;
      logic [CFG_DIM_BITS-1:0]     height_pixels;
      logic [CFG_DELAY_BITS-1:0]   long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic           fire;
      event_kind_type kind;
   } evt_type;

endpackage

`default_nettype wire

>>> rtl/core/tged_if.sv
// Channel interfaces of the touch gesture event detector: poll items,
// event items and register writes. Depends on tged_pkg.
`default_nettype none

interface tged_req_if #(
   parameter int COORD_BITS = tged_pkg::COORD_BITS_DEFAULT,
   parameter int TIME_BITS  = tged_pkg::TIME_BITS_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic [tged_pkg::COUNT_BITS-1:0] touch_count;
   logic [COORD_BITS-1:0]           raw_x;
   logic [COORD_BITS-1:0]           raw_y;
   logic [TIME_BITS-1:0]            now_ms;

   modport source (output valid, touch_count, raw_x, raw_y, now_ms, input ready);
   modport sink   (input valid, touch_count, raw_x, raw_y, now_ms, output ready);
endinterface

interface tged_rsp_if #(
   parameter int COORD_BITS = tged_pkg::COORD_BITS_DEFAULT
);
   logic                    valid;
   logic                    ready;
   tged_pkg::event_kind_type event_kind;
   logic [COORD_BITS-1:0]   point_x;
   logic [COORD_BITS-1:0]   point_y;

   modport source (output valid, event_kind, point_x, point_y, input ready);
   modport sink   (input valid, event_kind, point_x, point_y, output ready);
endinterface

interface tged_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tged_pkg::CSR_INDEX_BITS-1:0] index;
   logic [tged_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/touch_gesture_event_detector_unit.sv
// Top level of the touch gesture event detector: poll input register,
// mapping and tracking logic, event output register.
// Depends on tged_pkg, tged_if, tged_cfg, tged_map and tged_track.
//
//   Channel  Dir   Item                                     Handshake
//   req_ch   in    touch_count, raw_x, raw_y, now_ms         valid/ready
//   rsp_ch   out   event_kind, point_x, point_y              valid/ready
//   csr_ch   in    index, data (register write)              valid/ready, ready tied high
//
// One poll per clock while the event register is not stalled. A poll is held
// in the input register; mapping and event decision run between it and the
// event register, which drives rsp_ch. Polls that cause no event are dropped
// as they leave the input register. A stalled event register holds the input
// stage, which in turn drops req_ch.ready. Synchronous active-high reset
// clears both valid flags, the touch state and the registers to their
// documented defaults.
`default_nettype none

module touch_gesture_event_detector_unit #(
   parameter int COORD_BITS = tged_pkg::COORD_BITS_DEFAULT,
   parameter int TIME_BITS  = tged_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   tged_req_if.sink   req_ch,
   tged_rsp_if.source rsp_ch,
   tged_csr_if.sink   csr_ch
);
   import tged_pkg::*;

   cfg_type cfg;

   // input stage
   logic                  in_valid_ff, in_valid_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COORD_BITS-1:0] raw_x_ff;
   logic [COORD_BITS-1:0] raw_y_ff;
   logic [TIME_BITS-1:0]  now_ff;

   // output stage
   logic                  rsp_valid_ff, rsp_valid_in;
   event_kind_type        kind_ff;
   logic [COORD_BITS-1:0] point_x_ff;
   logic [COORD_BITS-1:0] point_y_ff;

   logic                  take;       // poll accepted this cycle
   logic                  advance;    // input stage item is processed
   logic [COORD_BITS-1:0] map_x, map_y;
   logic [COORD_BITS-1:0] pt_x, pt_y;
   evt_type               evt;

   tged_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   tged_map #(.COORD_BITS(COORD_BITS)) u_map (
      .cfg   (cfg),
      .raw_x (raw_x_ff),
      .raw_y (raw_y_ff),
      .map_x (map_x),
      .map_y (map_y)
   );

   tged_track #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_track (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .touch_count   (count_ff),
      .map_x         (map_x),
      .map_y         (map_y),
      .now_ms        (now_ff),
      .long_press_ms (cfg.long_press_ms),
      .evt           (evt),
      .point_x       (pt_x),
      .point_y       (pt_y)
   );

   // The input stage moves on whenever the event register is free or
   // being emptied this cycle.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && evt.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         count_ff <= req_ch.touch_count;
         raw_x_ff <= req_ch.raw_x;
         raw_y_ff <= req_ch.raw_y;
         now_ff   <= req_ch.now_ms;
      end
      if (advance && evt.fire) begin
         kind_ff    <= evt.kind;
         point_x_ff <= pt_x;
         point_y_ff <= pt_y;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_kind = kind_ff;
   assign rsp_ch.point_x    = point_x_ff;
   assign rsp_ch.point_y    = point_y_ff;

`ifndef ASSERT_OFF
   a_event_registered: assert property (@(posedge clock) disable iff (reset)
      (advance && evt.fire) |=> rsp_valid_ff)
      else $error("event lost on the way to the output register");

   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      take |=> in_valid_ff)
      else $error("accepted poll not held in input stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(now_ff) && $stable(count_ff)))
      else $error("input stage changed while stalled");

   a_no_fire_when_idle: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !advance)
      else $error("empty input stage processed");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tged_cfg.sv
// Configuration register file of the touch gesture event detector.
// Depends on tged_pkg and tged_if.
`default_nettype none

module tged_cfg (
   input  wire logic        clock,
   input  wire logic        reset,
   tged_csr_if.sink         csr_ch,
   output tged_pkg::cfg_type cfg
);
   import tged_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_ROTATION:      cfg_in.rotation          = rotation_type'(csr_ch.data[1:0]);
            CSR_MIRROR_HORIZ:  cfg_in.mirror_horizontal = csr_ch.data[0];
            CSR_MIRROR_VERT:   cfg_in.mirror_vertical   = csr_ch.data[0];
            CSR_WIDTH_PIXELS:  cfg_in.width_pixels      = csr_ch.data[CFG_DIM_BITS-1:0];
            CSR_HEIGHT_PIXELS: cfg_in.height_pixels     = csr_ch.data[CFG_DIM_BITS-1:0];
            CSR_LONG_PRESS_MS: cfg_in.long_press_ms     = csr_ch.data[CFG_DELAY_BITS-1:0];
            default:           cfg_in = cfg_ff;   // unused indexes are ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation          <= rotation_type'(RESET_ROTATION);
         cfg_ff.mirror_horizontal <= 1'b0;
         cfg_ff.mirror_vertical   <= 1'b0;
         cfg_ff.width_pixels      <= RESET_WIDTH;
         cfg_ff.height_pixels     <= RESET_HEIGHT;
         cfg_ff.long_press_ms     <= RESET_LONG_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/tged_map.sv
// Maps a raw panel point to screen coordinates by rotation and mirror flags.
// Pure combinational; depends on tged_pkg.
`default_nettype none

module tged_map #(
   parameter int COORD_BITS = tged_pkg::COORD_BITS_DEFAULT
) (
   input  wire tged_pkg::cfg_type   cfg,
   input  wire logic [COORD_BITS-1:0] raw_x,
   input  wire logic [COORD_BITS-1:0] raw_y,
   output logic [COORD_BITS-1:0]    map_x,
   output logic [COORD_BITS-1:0]    map_y
);
   import tged_pkg::*;

   localparam int SUB_W = (COORD_BITS > CFG_DIM_BITS) ? COORD_BITS : CFG_DIM_BITS;

   logic [SUB_W-1:0] w_e, h_e, rx_e, ry_e;
   logic [SUB_W-1:0] w_rx, w_ry, h_rx, h_ry;
   logic [SUB_W-1:0] x_sel, y_sel;

   // a - b clamped at zero
   function automatic logic [SUB_W-1:0] sat_sub(input logic [SUB_W-1:0] a,
                                                input logic [SUB_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   always_comb begin
      w_e  = SUB_W'(cfg.width_pixels);
      h_e  = SUB_W'(cfg.height_pixels);
      rx_e = SUB_W'(raw_x);
      ry_e = SUB_W'(raw_y);
      w_rx = sat_sub(w_e, rx_e);
      w_ry = sat_sub(w_e, ry_e);
      h_rx = sat_sub(h_e, rx_e);
      h_ry = sat_sub(h_e, ry_e);

      case (cfg.rotation)
         ROT_0: begin
            x_sel = cfg.mirror_vertical   ? w_rx : rx_e;
            y_sel = cfg.mirror_horizontal ? h_ry : ry_e;
         end
         ROT_90: begin
            x_sel = cfg.mirror_vertical   ? w_ry : ry_e;
            y_sel = cfg.mirror_horizontal ? rx_e : h_rx;
         end
         ROT_180: begin
            // resolutions stay swapped here on purpose
            x_sel = cfg.mirror_vertical   ? rx_e : h_rx;
            y_sel = cfg.mirror_horizontal ? ry_e : w_ry;
         end
         default: begin
            x_sel = cfg.mirror_vertical   ? ry_e : w_ry;
            y_sel = cfg.mirror_horizontal ? h_rx : rx_e;
         end
      endcase

      map_x = x_sel[COORD_BITS-1:0];
      map_y = y_sel[COORD_BITS-1:0];
   end

endmodule

`default_nettype wire

>>> rtl/core/tged_track.sv
// Touch state tracker: holds touch/long-press flags, last point and press
// time, and picks the event for each poll. Depends on tged_pkg.
`default_nettype none

module tged_track #(
   parameter int COORD_BITS = tged_pkg::COORD_BITS_DEFAULT,
   parameter int TIME_BITS  = tged_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step,
   input  wire logic [tged_pkg::COUNT_BITS-1:0]   touch_count,
   input  wire logic [COORD_BITS-1:0]             map_x,
   input  wire logic [COORD_BITS-1:0]             map_y,
   input  wire logic [TIME_BITS-1:0]              now_ms,
   input  wire logic [tged_pkg::CFG_DELAY_BITS-1:0] long_press_ms,
   output tged_pkg::evt_type                      evt,
   output logic [COORD_BITS-1:0]                  point_x,
   output logic [COORD_BITS-1:0]                  point_y
);
   import tged_pkg::*;

   logic                  is_touched_ff, is_touched_in;
   logic                  is_long_ff, is_long_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in;
   logic [COORD_BITS-1:0] last_y_ff, last_y_in;
   logic [TIME_BITS-1:0]  press_time_ff, press_time_in;
   logic [TIME_BITS-1:0]  deadline;
   logic                  moved;

   always_comb begin
      deadline      = press_time_ff + TIME_BITS'(long_press_ms);   // wraps
      moved         = (map_x != last_x_ff) || (map_y != last_y_ff);
      evt.fire      = 1'b0;
      evt.kind      = EV_PRESSED;
      is_touched_in = is_touched_ff;
      is_long_in    = is_long_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      press_time_in = press_time_ff;

      if (step) begin
         case (touch_count)
            TOUCH_ONE: begin
               if (!is_touched_ff) begin
                  evt.fire      = 1'b1;
                  evt.kind      = EV_PRESSED;
                  is_touched_in = 1'b1;
                  last_x_in     = map_x;
                  last_y_in     = map_y;
                  press_time_in = now_ms;
               end else if (moved) begin
                  evt.fire  = 1'b1;
                  evt.kind  = EV_MOVED;
                  last_x_in = map_x;
                  last_y_in = map_y;
               end else if (!is_long_ff && (now_ms > deadline)) begin
                  evt.fire      = 1'b1;
                  evt.kind      = EV_LONG_PRESSED;
                  is_long_in    = 1'b1;
                  press_time_in = now_ms + TIME_BITS'(LONG_HOLD_EXTRA_MS);
               end
            end
            TOUCH_NONE: begin
               if (is_touched_ff && !is_long_ff) begin
                  evt.fire      = 1'b1;
                  evt.kind      = EV_RELEASED;
                  is_touched_in = 1'b0;
               end else if (is_long_ff) begin
                  evt.fire      = 1'b1;
                  evt.kind      = EV_LONG_RELEASED;
                  is_touched_in = 1'b0;
                  is_long_in    = 1'b0;
               end
            end
            default: ;   // multi-touch polls are ignored
         endcase
      end
   end

   // events report the last point after this poll's update
   assign point_x = last_x_in;
   assign point_y = last_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_touched_ff <= 1'b0;
         is_long_ff    <= 1'b0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         press_time_ff <= '0;
      end else begin
         is_touched_ff <= is_touched_in;
         is_long_ff    <= is_long_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         press_time_ff <= press_time_in;
      end
   end

`ifndef ASSERT_OFF
   a_long_implies_touched: assert property (@(posedge clock) disable iff (reset)
      is_long_ff |-> is_touched_ff)
      else $error("long press flag set without touch");

   a_press_from_idle: assert property (@(posedge clock) disable iff (reset)
      (evt.fire && evt.kind == EV_PRESSED) |-> !is_touched_ff)
      else $error("pressed event while already touched");

   a_multi_touch_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && touch_count != TOUCH_ONE && touch_count != TOUCH_NONE)
         |=> ($stable(is_touched_ff) && $stable(is_long_ff) && $stable(press_time_ff)))
      else $error("multi-touch poll changed state");

   a_long_release_after_long: assert property (@(posedge clock) disable iff (reset)
      (evt.fire && evt.kind == EV_LONG_RELEASED) |-> is_long_ff)
      else $error("long release without long press");
`endif

endmodule

`default_nettype wire
